// File: src/m4au_pkg.sv
// Shared types and command codes for the 4x4 matrix affine unit.
package m4au_pkg;

    localparam int ELEM_W = 32;

    localparam logic [2:0] CMD_LOAD = 3'd0;
    localparam logic [2:0] CMD_MUL  = 3'd1;
    localparam logic [2:0] CMD_TR   = 3'd2;
    localparam logic [2:0] CMD_INV  = 3'd3;
    localparam logic [2:0] CMD_READ = 3'd4;

    typedef struct packed {
        logic [2:0]               command;
        logic [1:0]               col;
        logic signed [ELEM_W-1:0] elem_0;
        logic signed [ELEM_W-1:0] elem_1;
        logic signed [ELEM_W-1:0] elem_2;
        logic signed [ELEM_W-1:0] elem_3;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               out_col;
        logic signed [ELEM_W-1:0] out_0;
        logic signed [ELEM_W-1:0] out_1;
        logic signed [ELEM_W-1:0] out_2;
        logic signed [ELEM_W-1:0] out_3;
        logic                     saturated;
    } t_out_item;

    // control that rides with one MAC operand pair
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic negate;
    } t_mac_ctl;

    // one finished dot product
    typedef struct packed {
        logic                     valid;
        logic signed [ELEM_W-1:0] value;
        logic                     sat;
    } t_mac_res;

endpackage

// File: src/m4au_mac.sv
// Shared multiply-accumulate unit: floored fixed-point products, exact sum, saturation.
module m4au_mac #(
    parameter int FRAC_BITS = 16,
    parameter int SAT_BITS  = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic signed [m4au_pkg::ELEM_W-1:0]    i_a,
    input  logic signed [m4au_pkg::ELEM_W-1:0]    i_b,
    input  m4au_pkg::t_mac_ctl                    i_ctl,
    output m4au_pkg::t_mac_res                    o_res
);

    localparam int PROD_W = 2 * m4au_pkg::ELEM_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W - SAT_BITS + 1){1'b0}}, {(SAT_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    m4au_pkg::t_mac_ctl       r_ctl1;
    logic signed [ACC_W-1:0]  w_sum;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_fin;
    logic                     r_fin_v;
    logic                     r_fin_neg;
    logic signed [ACC_W-1:0]  w_fin;

    assign w_prod = i_a * i_b;
    assign w_sum  = (r_ctl1.first ? ACC_W'(0) : r_acc) + ACC_W'(r_prod);
    assign w_fin  = r_fin_neg ? -r_fin : r_fin;

    // stage 1: product, floored by the arithmetic shift
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod >>> FRAC_BITS;
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
        end
    end

    // stage 2: accumulate
    always_ff @(posedge i_clk) begin
        if (r_ctl1.valid) begin
            r_acc <= w_sum;
        end
        if (r_ctl1.valid && r_ctl1.last) begin
            r_fin     <= w_sum;
            r_fin_neg <= r_ctl1.negate;
        end
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else begin
            r_fin_v <= r_ctl1.valid && r_ctl1.last;
        end
    end

    // stage 3: optional negate, then saturate
    always_ff @(posedge i_clk) begin
        priority if (w_fin > SAT_MAX) begin
            o_res.value <= SAT_MAX[m4au_pkg::ELEM_W-1:0];
            o_res.sat   <= 1'b1;
        end else if (w_fin < SAT_MIN) begin
            o_res.value <= SAT_MIN[m4au_pkg::ELEM_W-1:0];
            o_res.sat   <= 1'b1;
        end else begin
            o_res.value <= w_fin[m4au_pkg::ELEM_W-1:0];
            o_res.sat   <= 1'b0;
        end
        if (!i_rst_n) begin
            o_res.valid <= 1'b0;
        end else begin
            o_res.valid <= r_fin_v;
        end
    end

endmodule

// File: src/matrix4_affine_unit.sv
// Top level of the 4x4 matrix affine unit: matrix store, staging store and sequencer.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+----------------------------
//  in      | in  | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//  out     | out | o_out_valid / i_out_stall | o_out_item (t_out_item)
//
// One item at a time; o_in_stall is high from accept until the result is in
// the output register. A multiply makes 16 passes through the one multiplier
// (4-deep pipeline); a rigid inverse makes 9 passes, the update and 4 column
// reads through one read port. Synchronous active-low reset restores the
// identity. A stalled output holds its item; the next item is accepted and
// its result waits for the register.
module matrix4_affine_unit #(
    parameter int FRAC_BITS  = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  m4au_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output m4au_pkg::t_out_item o_out_item
);

    localparam int EW       = m4au_pkg::ELEM_W;
    localparam int SAT_BITS = (ELEM_WIDTH > 32) ? 32 : ELEM_WIDTH;
    localparam logic [EW-1:0] ONE_FIX = EW'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_WAIT,
        S_APPLY,
        S_OUT_RD,
        S_PUSH
    } t_state;

    t_state                r_state;
    logic [2:0]            r_cmd;
    logic [1:0]            r_col;
    logic signed [EW-1:0]  r_e   [4];
    logic [1:0]            r_row;
    logic [1:0]            r_k;
    logic [1:0]            r_ridx;
    logic [2:0]            r_cnt;
    logic [2:0]            w_cnt_m1;
    logic [EW-1:0]         r_res [4];
    logic                  r_sat;
    logic [EW-1:0]         r_tr  [3];
    logic                  r_tflag;
    logic                  r_out_valid;
    m4au_pkg::t_out_item   r_out;

    // matrix and staging, column-major: index = {col, row}
    logic [EW-1:0]         r_mat   [16];
    logic [EW-1:0]         r_stage [16];

    logic signed [EW-1:0]  r_op_a;
    logic signed [EW-1:0]  r_op_b;
    m4au_pkg::t_mac_ctl    r_op_ctl;
    m4au_pkg::t_mac_res    w_mac_res;

    logic                  w_accept;
    logic                  w_push;
    logic                  w_is_inv;
    logic                  w_is_mul;
    logic [1:0]            w_last;
    logic [3:0]            w_rd_addr;
    logic signed [EW-1:0]  w_in_e [4];

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_push   = (r_state == S_PUSH) && (!r_out_valid || !i_out_stall);
    assign w_is_inv = (r_cmd == m4au_pkg::CMD_INV);
    assign w_is_mul = (r_cmd == m4au_pkg::CMD_MUL);
    // inverse works on the 3x3 rotation, multiply on the full 4x4
    assign w_last   = w_is_inv ? 2'd2 : 2'd3;
    assign w_cnt_m1 = r_cnt - 3'd1;

    assign w_in_e[0] = i_in_item.elem_0;
    assign w_in_e[1] = i_in_item.elem_1;
    assign w_in_e[2] = i_in_item.elem_2;
    assign w_in_e[3] = i_in_item.elem_3;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // single matrix read port
    always_comb begin
        unique case (r_state)
            S_MAC:    w_rd_addr = w_is_inv ? {r_row, r_k} : {r_k, r_row};
            S_OUT_RD: w_rd_addr = {r_col, r_cnt[1:0]};
            default:  w_rd_addr = '0;
        endcase
    end

    // operand register in front of the MAC
    always_ff @(posedge i_clk) begin
        r_op_a <= r_mat[w_rd_addr];
        r_op_b <= r_e[r_k];
        r_op_ctl.first  <= (r_k == 2'd0);
        r_op_ctl.last   <= (r_k == w_last);
        r_op_ctl.negate <= w_is_inv;
        if (!i_rst_n) begin
            r_op_ctl.valid <= 1'b0;
        end else begin
            r_op_ctl.valid <= (r_state == S_MAC);
        end
    end

    m4au_mac #(
        .FRAC_BITS (FRAC_BITS),
        .SAT_BITS  (SAT_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (r_op_a),
        .i_b     (r_op_b),
        .i_ctl   (r_op_ctl),
        .o_res   (w_mac_res)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= i_in_item.command;
                        r_col   <= i_in_item.col;
                        r_row   <= '0;
                        r_k     <= '0;
                        r_ridx  <= '0;
                        r_cnt   <= '0;
                        r_sat   <= 1'b0;
                        r_tflag <= 1'b0;
                        unique case (i_in_item.command)
                            m4au_pkg::CMD_LOAD: begin
                                for (int i = 0; i < 4; i++) begin
                                    r_res[i] <= w_in_e[i];
                                end
                                r_state <= S_PUSH;
                            end
                            m4au_pkg::CMD_MUL: begin
                                for (int i = 0; i < 4; i++) begin
                                    r_e[i] <= w_in_e[i];
                                end
                                r_state <= S_MAC;
                            end
                            m4au_pkg::CMD_TR: begin
                                r_state <= S_APPLY;
                            end
                            m4au_pkg::CMD_INV: begin
                                // translation column is the second operand
                                for (int i = 0; i < 4; i++) begin
                                    r_e[i] <= r_mat[12 + i];
                                end
                                r_state <= S_MAC;
                            end
                            default: begin
                                // read, and unused codes act as read
                                r_state <= S_OUT_RD;
                            end
                        endcase
                    end
                end
                S_MAC: begin
                    if (r_k == w_last) begin
                        r_k <= '0;
                        if (r_row == w_last) begin
                            r_state <= S_WAIT;
                        end else begin
                            r_row <= r_row + 2'd1;
                        end
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_WAIT: begin
                    // left on the final MAC result, below
                end
                S_APPLY: begin
                    r_sat   <= w_is_inv && (r_col == 2'd3) && r_tflag;
                    r_state <= S_OUT_RD;
                end
                S_OUT_RD: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt != 3'd0) begin
                        r_res[w_cnt_m1[1:0]] <= r_op_a;
                    end
                    if (r_cnt == 3'd4) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (w_push) begin
                        r_out_valid       <= 1'b1;
                        r_out.out_col     <= r_col;
                        r_out.out_0       <= r_res[0];
                        r_out.out_1       <= r_res[1];
                        r_out.out_2       <= r_res[2];
                        r_out.out_3       <= r_res[3];
                        r_out.saturated   <= r_sat;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // finished dot products, one per result row
            if (w_mac_res.valid) begin
                r_ridx <= r_ridx + 2'd1;
                if (w_is_inv) begin
                    r_tr[r_ridx] <= w_mac_res.value;
                    r_tflag      <= r_tflag | w_mac_res.sat;
                end else begin
                    r_res[r_ridx] <= w_mac_res.value;
                    r_sat         <= r_sat | w_mac_res.sat;
                end
                if (r_ridx == w_last) begin
                    r_state <= w_is_mul ? S_PUSH : S_APPLY;
                end
            end
        end
    end

    // staging store: multiply results at their own column
    always_ff @(posedge i_clk) begin
        if (w_mac_res.valid && w_is_mul) begin
            r_stage[{r_col, r_ridx}] <= w_mac_res.value;
        end
    end

    // matrix store; the update sources are active in different states
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= (i / 4 == i % 4) ? ONE_FIX : '0;
            end
        end else begin
            if (w_accept && (i_in_item.command == m4au_pkg::CMD_LOAD)) begin
                for (int i = 0; i < 4; i++) begin
                    r_mat[{i_in_item.col, 2'(i)}] <= w_in_e[i];
                end
            end else if ((r_state == S_APPLY) && w_is_inv) begin
                for (int k = 0; k < 3; k++) begin
                    for (int r = 0; r < 3; r++) begin
                        r_mat[k * 4 + r] <= r_mat[r * 4 + k];
                    end
                    r_mat[12 + k]   <= r_tr[k];
                    r_mat[k * 4 + 3] <= '0;
                end
                r_mat[15] <= ONE_FIX;
            end else if (r_state == S_APPLY) begin
                for (int k = 0; k < 4; k++) begin
                    for (int r = 0; r < 4; r++) begin
                        r_mat[k * 4 + r] <= r_mat[r * 4 + k];
                    end
                end
            end else if (w_push && w_is_mul && (r_col == 2'd3)) begin
                // commit the staged product
                for (int i = 0; i < 16; i++) begin
                    r_mat[i] <= r_stage[i];
                end
            end
        end
    end

    // MAC results only arrive while a dot-product pass is under way
    a_mac_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_res.valid |-> (r_state == S_MAC || r_state == S_WAIT))
        else $error("MAC result outside a dot-product pass");

    // an accepted item blocks the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input not stalled after accept");

    // rigid inverse leaves row 3 as 0,0,0,1
    a_inv_row3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && w_is_inv) |=>
            (r_mat[15] == ONE_FIX && r_mat[3] == '0 && r_mat[7] == '0 && r_mat[11] == '0))
        else $error("inverse row 3 wrong");

    // an inverse pass never produces more rows than the three it issued
    a_ridx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mac_res.valid && w_is_inv) |-> (r_ridx != 2'd3))
        else $error("too many inverse results");

endmodule
